// File: sv/iso2ep_pkg.sv
// Shared types, constants and calendar helpers for the timestamp parser.
`default_nettype none

package iso2ep_pkg;

  // Parser phase inside one string
  typedef enum logic [2:0] {
    PH_MAIN = 3'd0,  // date and time part
    PH_ZONE = 3'd1,  // zone or fraction expected
    PH_FRAC = 3'd2,  // inside fractional seconds
    PH_ZEND = 3'd3,  // after Z / z
    PH_OFFP = 3'd4,  // +HH[:]MM
    PH_OFFM = 3'd5   // -HH[:]MM
  } phase_e;

  typedef enum logic [1:0] {
    ZN_UTC   = 2'd0,
    ZN_PLUS  = 2'd1,
    ZN_MINUS = 2'd2
  } zone_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_CONV = 1'b1
  } back_e;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned FLD_W  = 7;
  localparam int unsigned OFF_W  = 18;
  localparam int unsigned EPOCH_W = 33;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1970;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd2100;

  // Parsed string, handed from front to back
  typedef struct packed {
    logic               fmt_ok;
    zone_e              zone;
    logic [YEAR_W-1:0]  year;
    logic [FLD_W-1:0]   month;
    logic [FLD_W-1:0]   day;
    logic [FLD_W-1:0]   hour;
    logic [FLD_W-1:0]   minute;
    logic [FLD_W-1:0]   second;
    logic [OFF_W-1:0]   offset;
  } rec_t;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Days in a month; leap rule only needs to hold for 1970..2100
  function automatic logic [4:0] month_days(input logic [YEAR_W-1:0] year,
                                            input logic [FLD_W-1:0] month);
    logic leap;
    logic [4:0] n;
    leap = (year[1:0] == 2'b00) && (year != YEAR_MAX);
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                     n = 5'd30;
      7'd2:                                        n = leap ? 5'd29 : 5'd28;
      default:                                     n = 5'd0;
    endcase
    return n;
  endfunction

  // Days before the month start, counting from March
  function automatic logic [8:0] march_base(input logic [3:0] am);
    logic [8:0] b;
    case (am)
      4'd0:    b = 9'd0;
      4'd1:    b = 9'd31;
      4'd2:    b = 9'd61;
      4'd3:    b = 9'd92;
      4'd4:    b = 9'd122;
      4'd5:    b = 9'd153;
      4'd6:    b = 9'd184;
      4'd7:    b = 9'd214;
      4'd8:    b = 9'd245;
      4'd9:    b = 9'd275;
      4'd10:   b = 9'd306;
      4'd11:   b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: sv/iso2ep_front.sv
// Character parser: checks the form and gathers the fields of one string.
`default_nettype none

module iso2ep_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic              last_char_i,
  output logic                   push_o,
  output iso2ep_pkg::rec_t       rec_o
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_ZU    = 8'h5A;
  localparam logic [7:0] CH_ZL    = 8'h7A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  iso2ep_pkg::phase_e phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [iso2ep_pkg::YEAR_W-1:0] year_q, year_d;
  logic [iso2ep_pkg::FLD_W-1:0]  month_q, month_d, day_q, day_d;
  logic [iso2ep_pkg::FLD_W-1:0]  hour_q, hour_d, min_q, min_d, sec_q, sec_d;
  logic [iso2ep_pkg::OFF_W-1:0]  off_q, off_d;
  logic err_q, err_d, ended_q, ended_d;

  logic       is_dig;
  logic [3:0] dig;
  logic [6:0] hh;
  iso2ep_pkg::phase_e   ph_n;
  logic [4:0]           pos_n;
  logic [iso2ep_pkg::YEAR_W-1:0] year_n;
  logic [iso2ep_pkg::FLD_W-1:0]  month_n, day_n, hour_n, min_n, sec_n;
  logic [iso2ep_pkg::OFF_W-1:0]  off_n;
  logic err_n, ended_n;

  assign is_dig = (char_code_i >= CH_0) && (char_code_i <= CH_9);
  assign dig    = char_code_i[3:0];
  assign hh     = off_q[6:0] + 7'(dig);

  // Next parse state for the incoming character
  always_comb begin
    ph_n    = phase_q;
    pos_n   = pos_q;
    year_n  = year_q;
    month_n = month_q;
    day_n   = day_q;
    hour_n  = hour_q;
    min_n   = min_q;
    sec_n   = sec_q;
    off_n   = off_q;
    err_n   = err_q;
    ended_n = ended_q;
    if (!ended_q && !err_q) begin
      if (char_code_i == CH_NUL) begin
        ended_n = 1'b1;
      end else begin
        unique case (phase_q)
          iso2ep_pkg::PH_MAIN: begin
            // separators at 4, 7 (-), 10 (T or space), 13, 16 (:)
            if (pos_q == 5'd4 || pos_q == 5'd7) begin
              if (char_code_i != CH_DASH) err_n = 1'b1;
            end else if (pos_q == 5'd10) begin
              if (char_code_i != CH_T && char_code_i != CH_SPACE) err_n = 1'b1;
            end else if (pos_q == 5'd13 || pos_q == 5'd16) begin
              if (char_code_i != CH_COLON) err_n = 1'b1;
            end else if (!is_dig) begin
              err_n = 1'b1;
            end else if (pos_q <= 5'd3) begin
              year_n = 14'(year_q * 14'd10 + 14'(dig));
            end else if (pos_q <= 5'd6) begin
              month_n = 7'(month_q * 7'd10 + 7'(dig));
            end else if (pos_q <= 5'd9) begin
              day_n = 7'(day_q * 7'd10 + 7'(dig));
            end else if (pos_q <= 5'd12) begin
              hour_n = 7'(hour_q * 7'd10 + 7'(dig));
            end else if (pos_q <= 5'd15) begin
              min_n = 7'(min_q * 7'd10 + 7'(dig));
            end else begin
              sec_n = 7'(sec_q * 7'd10 + 7'(dig));
            end
            if (pos_q >= 5'd18) begin
              ph_n  = iso2ep_pkg::PH_ZONE;
              pos_n = 5'd0;
            end else begin
              pos_n = pos_q + 5'd1;
            end
          end
          iso2ep_pkg::PH_ZONE, iso2ep_pkg::PH_FRAC: begin
            if (phase_q == iso2ep_pkg::PH_ZONE && char_code_i == CH_DOT) begin
              ph_n = iso2ep_pkg::PH_FRAC;
            end else if (phase_q == iso2ep_pkg::PH_FRAC && is_dig) begin
              ph_n = phase_q;   // fraction digits dropped
            end else if (char_code_i == CH_ZU || char_code_i == CH_ZL) begin
              ph_n = iso2ep_pkg::PH_ZEND;
            end else if (char_code_i == CH_PLUS || char_code_i == CH_DASH) begin
              ph_n  = (char_code_i == CH_PLUS) ? iso2ep_pkg::PH_OFFP
                                               : iso2ep_pkg::PH_OFFM;
              pos_n = 5'd0;
              off_n = '0;
            end else begin
              err_n = 1'b1;
            end
          end
          iso2ep_pkg::PH_OFFP, iso2ep_pkg::PH_OFFM: begin
            if (pos_q == 5'd0) begin
              if (!is_dig) err_n = 1'b1;
              else begin
                off_n = 18'(dig) * 18'd10;
                pos_n = 5'd1;
              end
            end else if (pos_q == 5'd1) begin
              if (!is_dig || hh > 7'd23) err_n = 1'b1;
              else begin
                off_n = 18'(hh) * 18'd3600;
                pos_n = 5'd2;
              end
            end else if (pos_q == 5'd2 && char_code_i == CH_COLON) begin
              pos_n = 5'd3;
            end else if (pos_q == 5'd2 || pos_q == 5'd3) begin
              if (!is_dig || dig > 4'd5) err_n = 1'b1;
              else begin
                off_n = off_q + 18'(dig) * 18'd600;
                pos_n = 5'd4;
              end
            end else if (pos_q == 5'd4) begin
              if (!is_dig) err_n = 1'b1;
              else begin
                off_n = off_q + 18'(dig) * 18'd60;
                pos_n = 5'd5;
              end
            end else begin
              err_n = 1'b1;
            end
          end
          default: err_n = 1'b1;   // nothing may follow Z
        endcase
      end
    end
  end

  // Commit on a taken character; the end of a string clears everything
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    off_d   = off_q;
    err_d   = err_q;
    ended_d = ended_q;
    if (take_i) begin
      if (last_char_i) begin
        phase_d = iso2ep_pkg::PH_MAIN;
        pos_d   = '0;
        year_d  = '0;
        month_d = '0;
        day_d   = '0;
        hour_d  = '0;
        min_d   = '0;
        sec_d   = '0;
        off_d   = '0;
        err_d   = 1'b0;
        ended_d = 1'b0;
      end else begin
        phase_d = ph_n;
        pos_d   = pos_n;
        year_d  = year_n;
        month_d = month_n;
        day_d   = day_n;
        hour_d  = hour_n;
        min_d   = min_n;
        sec_d   = sec_n;
        off_d   = off_n;
        err_d   = err_n;
        ended_d = ended_n;
      end
    end
  end

  assign push_o = take_i && last_char_i;

  always_comb begin
    rec_o.fmt_ok = !err_n && (ph_n != iso2ep_pkg::PH_MAIN) &&
                   !((ph_n == iso2ep_pkg::PH_OFFP || ph_n == iso2ep_pkg::PH_OFFM) &&
                     pos_n != 5'd5);
    if (ph_n == iso2ep_pkg::PH_OFFP)      rec_o.zone = iso2ep_pkg::ZN_PLUS;
    else if (ph_n == iso2ep_pkg::PH_OFFM) rec_o.zone = iso2ep_pkg::ZN_MINUS;
    else                                  rec_o.zone = iso2ep_pkg::ZN_UTC;
    rec_o.year   = year_n;
    rec_o.month  = month_n;
    rec_o.day    = day_n;
    rec_o.hour   = hour_n;
    rec_o.minute = min_n;
    rec_o.second = sec_n;
    rec_o.offset = off_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= iso2ep_pkg::PH_MAIN;
      pos_q   <= '0;
      year_q  <= '0;
      month_q <= '0;
      day_q   <= '0;
      hour_q  <= '0;
      min_q   <= '0;
      sec_q   <= '0;
      off_q   <= '0;
      err_q   <= 1'b0;
      ended_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      off_q   <= off_d;
      err_q   <= err_d;
      ended_q <= ended_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/iso2ep_queue.sv
// Small FIFO of parsed strings between parser and converter.
`default_nettype none

module iso2ep_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire iso2ep_pkg::rec_t  rec_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   nempty_o,
  output iso2ep_pkg::rec_t       rec_o
);

  iso2ep_pkg::rec_t mem_q [iso2ep_pkg::Q_DEPTH];
  logic [iso2ep_pkg::Q_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [iso2ep_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o   = (cnt_q == iso2ep_pkg::Q_CNT_W'(iso2ep_pkg::Q_DEPTH));
  assign nempty_o = (cnt_q != '0);
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && nempty_o;
  assign rec_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == iso2ep_pkg::Q_PTR_W'(iso2ep_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == iso2ep_pkg::Q_PTR_W'(iso2ep_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/iso2ep_back.sv
// Converter: range checks, day count and epoch seconds, with output register.
`default_nettype none

module iso2ep_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    nempty_i,
  input  wire iso2ep_pkg::rec_t        rec_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         valid_res_o,
  output logic signed [iso2ep_pkg::EPOCH_W-1:0] epoch_seconds_o
);

  iso2ep_pkg::back_e st_q, st_d;

  logic        ok_q, ok_d;
  logic [15:0] days_q, days_d;
  logic signed [18:0] part_q, part_d;

  logic        out_valid_q, out_valid_d;
  logic        res_q, res_d;
  logic [iso2ep_pkg::EPOCH_W-1:0] epoch_q, epoch_d;

  logic        ok;
  logic [4:0]  mdays;
  logic [iso2ep_pkg::YEAR_W-1:0] yy;
  logic [7:0]  yr;        // years since 1968, March based
  logic [3:0]  am;
  logic [16:0] days_w;
  logic [16:0] tod;
  logic [iso2ep_pkg::EPOCH_W-1:0] prod;
  logic        slot_free;

  assign mdays = iso2ep_pkg::month_days(rec_i.year, rec_i.month);

  always_comb begin
    ok = rec_i.fmt_ok &&
         (rec_i.year >= iso2ep_pkg::YEAR_MIN) && (rec_i.year <= iso2ep_pkg::YEAR_MAX) &&
         (rec_i.month >= 7'd1) && (rec_i.month <= 7'd12) &&
         (rec_i.day >= 7'd1) && (rec_i.day <= 7'(mdays)) &&
         (rec_i.hour <= 7'd23) && (rec_i.minute <= 7'd59) && (rec_i.second <= 7'd60);
    yy = rec_i.year - ((rec_i.month <= 7'd2) ? 14'd1 : 14'd0);
    yr = 8'(yy - 14'd1968);
    am = (rec_i.month > 7'd2) ? 4'(rec_i.month - 7'd3) : 4'(rec_i.month + 7'd9);
    // 365*y + y/4 + day-of-year, minus the 1968..1970 offset; 2100 skips a leap day
    days_w = 17'(yr) * 17'd365 + 17'(yr >> 2) +
             17'(iso2ep_pkg::march_base(am)) + 17'(rec_i.day) - 17'd672 -
             ((yr == 8'd132) ? 17'd1 : 17'd0);
    tod = 17'(rec_i.hour) * 17'd3600 + 17'(rec_i.minute) * 17'd60 + 17'(rec_i.second);
  end

  assign slot_free = !out_valid_q || !out_stall_i;
  assign prod      = 33'(days_q) * 33'd86400;

  always_comb begin
    st_d        = st_q;
    pop_o       = 1'b0;
    ok_d        = ok_q;
    days_d      = days_q;
    part_d      = part_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    epoch_d     = epoch_q;
    unique case (st_q)
      iso2ep_pkg::BK_IDLE: begin
        if (nempty_i) begin
          pop_o  = 1'b1;
          ok_d   = ok;
          days_d = days_w[15:0];
          unique case (rec_i.zone)
            iso2ep_pkg::ZN_PLUS:  part_d = signed'({2'b00, tod}) - signed'({1'b0, rec_i.offset});
            iso2ep_pkg::ZN_MINUS: part_d = signed'({2'b00, tod}) + signed'({1'b0, rec_i.offset});
            default:              part_d = signed'({2'b00, tod});
          endcase
          st_d = iso2ep_pkg::BK_CONV;
        end
      end
      iso2ep_pkg::BK_CONV: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          res_d       = ok_q;
          epoch_d     = ok_q ? prod + {{(iso2ep_pkg::EPOCH_W-19){part_q[18]}}, part_q} : '0;
          st_d        = iso2ep_pkg::BK_IDLE;
        end
      end
      default: st_d = iso2ep_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= iso2ep_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q    <= ok_d;
    days_q  <= days_d;
    part_q  <= part_d;
    res_q   <= res_d;
    epoch_q <= epoch_d;
  end

  assign out_valid_o     = out_valid_q;
  assign valid_res_o     = res_q;
  assign epoch_seconds_o = signed'(epoch_q);

endmodule

`default_nettype wire

// File: sv/iso8601_utc_to_epoch_parser_top.sv
// Top level: ISO 8601 timestamp string to UTC epoch seconds.
//
//  Channel  Dir  Handshake              Payload
//  -------  ---  ---------------------  ----------------------------------------
//  in       in   in_valid_i/in_stall_o  char_code_i[7:0], last_char_i
//  out      out  out_valid_o/out_stall_i valid_res_o, epoch_seconds_o[32:0] (s)
//
// One character is taken per cycle while the queue is not full; the parser keeps
// no backlog of its own. The converter works each string in two steps (day
// count and tod, then the multiply by 86400) and takes the next string only
// once the last result is in the output register.
// A two-entry queue sits between parser and converter; input stalls only
// while it is full. Reset is asynchronous, active low; no clearing pass.
`default_nettype none

module iso8601_utc_to_epoch_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        last_char_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             valid_res_o,
  output logic signed [iso2ep_pkg::EPOCH_W-1:0] epoch_seconds_o
);

  iso2ep_pkg::rec_t push_rec, pop_rec;
  logic take, push, full, nempty, pop;

  // Stall on a full queue, whether or not this character ends a string
  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  iso2ep_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  iso2ep_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .rec_i    (push_rec),
    .full_o   (full),
    .pop_i    (pop),
    .nempty_o (nempty),
    .rec_o    (pop_rec)
  );

  iso2ep_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .nempty_i        (nempty),
    .rec_i           (pop_rec),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .valid_res_o     (valid_res_o),
    .epoch_seconds_o (epoch_seconds_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/iso2ep_epoch_checker.sv
`timescale 1ns / 1ps
// Checker: predicts the epoch result of each timestamp string and compares the parser's output.
module iso2ep_epoch_checker
  import iso2ep_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_stall_i,
  input  wire logic [7:0]                char_code_i,
  input  wire logic                      last_char_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_stall_i,
  input  wire logic                      valid_res_i,
  input  wire logic signed [EPOCH_W-1:0] epoch_seconds_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    epochs_due_o,
  output int unsigned                    epochs_checked_o,
  output int unsigned                    epochs_valid_o
);

  localparam logic [7:0] NUL = 8'h00;
  localparam int unsigned PRINT_CAP = 40;
  // days before the first of each month in a common year
  localparam int DAYS_BEFORE [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct packed {
    logic                      ok;
    logic signed [EPOCH_W-1:0] secs;
  } epoch_due_t;

  epoch_due_t        due_q[$];
  epoch_due_t        want;
  logic [4:0]        pos;
  phase_e            ph;
  logic [YEAR_W-1:0] yr_acc;
  logic [FLD_W-1:0]  mon_acc, day_acc, hr_acc, min_acc, sec_acc;
  logic [OFF_W-1:0]  off_acc;
  logic              form_bad, nul_seen;

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    if (mismatches_o < PRINT_CAP) begin
      $display("%0t ns: %s mismatch: got %0d, want %0d", $time, what, got, exp_val);
    end
    mismatches_o++;
  endtask

  task automatic clear_stamp();
    pos = '0;
    ph = PH_MAIN;
    yr_acc = '0;
    mon_acc = '0;
    day_acc = '0;
    hr_acc = '0;
    min_acc = '0;
    sec_acc = '0;
    off_acc = '0;
    form_bad = 1'b0;
    nul_seen = 1'b0;
  endtask

  task automatic start_zone(input logic [7:0] c);
    if (c == "Z" || c == "z") begin
      ph = PH_ZEND;
    end else if (c == "+" || c == "-") begin
      ph = (c == "+") ? PH_OFFP : PH_OFFM;
      pos = '0;
      off_acc = '0;
    end else begin
      form_bad = 1'b1;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    logic       dig;
    logic [3:0] dv;
    logic [6:0] hr_sum;
    dig = (c >= "0" && c <= "9");
    dv = 4'(c - "0");
    if (nul_seen || form_bad) return;
    if (c == NUL) begin
      nul_seen = 1'b1;
      return;
    end
    case (ph)
      PH_MAIN: begin
        if (pos == 5'd4 || pos == 5'd7) begin
          if (c != "-") form_bad = 1'b1;
        end else if (pos == 5'd10) begin
          if (c != "T" && c != " ") form_bad = 1'b1;
        end else if (pos == 5'd13 || pos == 5'd16) begin
          if (c != ":") form_bad = 1'b1;
        end else if (!dig) begin
          form_bad = 1'b1;
        end else if (pos <= 5'd3) begin
          yr_acc = yr_acc * 14'd10 + 14'(dv);
        end else if (pos <= 5'd6) begin
          mon_acc = mon_acc * 7'd10 + 7'(dv);
        end else if (pos <= 5'd9) begin
          day_acc = day_acc * 7'd10 + 7'(dv);
        end else if (pos <= 5'd12) begin
          hr_acc = hr_acc * 7'd10 + 7'(dv);
        end else if (pos <= 5'd15) begin
          min_acc = min_acc * 7'd10 + 7'(dv);
        end else begin
          sec_acc = sec_acc * 7'd10 + 7'(dv);
        end
        if (pos >= 5'd18) begin
          ph = PH_ZONE;
          pos = '0;
        end else begin
          pos = pos + 5'd1;
        end
      end
      PH_ZONE: begin
        if (c == ".") ph = PH_FRAC;
        else start_zone(c);
      end
      PH_FRAC: begin
        if (!dig) start_zone(c);
      end
      PH_OFFP, PH_OFFM: begin
        // offset digits: HH, optional colon, MM; tens of minutes at most 5
        if (pos == 5'd0) begin
          if (!dig) form_bad = 1'b1;
          else begin
            off_acc = 18'(dv) * 18'd10;
            pos = 5'd1;
          end
        end else if (pos == 5'd1) begin
          hr_sum = 7'(off_acc) + 7'(dv);
          if (!dig || hr_sum > 7'd23) form_bad = 1'b1;
          else begin
            off_acc = 18'(hr_sum) * 18'd3600;
            pos = 5'd2;
          end
        end else if (pos == 5'd2 && c == ":") begin
          pos = 5'd3;
        end else if (pos == 5'd2 || pos == 5'd3) begin
          if (!dig || dv > 4'd5) form_bad = 1'b1;
          else begin
            off_acc = off_acc + 18'(dv) * 18'd600;
            pos = 5'd4;
          end
        end else if (pos == 5'd4) begin
          if (!dig) form_bad = 1'b1;
          else begin
            off_acc = off_acc + 18'(dv) * 18'd60;
            pos = 5'd5;
          end
        end else begin
          form_bad = 1'b1;
        end
      end
      default: form_bad = 1'b1;  // anything after Z
    endcase
  endtask

  task automatic close_stamp();
    logic       ok, leap;
    int         y, mdays, days;
    longint     secs;
    epoch_due_t due;
    y = int'(yr_acc);
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (mon_acc)
      7'd2:                                       mdays = leap ? 29 : 28;
      7'd4, 7'd6, 7'd9, 7'd11:                    mdays = 30;
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: mdays = 31;
      default:                                    mdays = 0;
    endcase
    ok = !form_bad && ph != PH_MAIN;
    if ((ph == PH_OFFP || ph == PH_OFFM) && pos != 5'd5) ok = 1'b0;
    if (yr_acc < YEAR_MIN || yr_acc > YEAR_MAX) ok = 1'b0;
    // a bad month gives zero days, so the day test also rejects it
    if (day_acc < 7'd1 || int'(day_acc) > mdays) ok = 1'b0;
    if (hr_acc > 7'd23 || min_acc > 7'd59 || sec_acc > 7'd60) ok = 1'b0;
    secs = 0;
    if (ok) begin
      // whole years, leap days since 1970 (477 leap years up to 1969), then the month
      days = 365 * (y - 1970) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 - 477
           + DAYS_BEFORE[mon_acc - 7'd1] + ((mon_acc > 7'd2 && leap) ? 1 : 0)
           + int'(day_acc) - 1;
      secs = longint'(days) * 86400 + int'(hr_acc) * 3600 + int'(min_acc) * 60
           + int'(sec_acc);
      if (ph == PH_OFFP) secs = secs - longint'(off_acc);
      else if (ph == PH_OFFM) secs = secs + longint'(off_acc);
    end
    due.ok = ok;
    due.secs = secs[EPOCH_W-1:0];
    due_q.push_back(due);
    clear_stamp();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_stamp();
      due_q.delete();
      epochs_due_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          report_mismatch("unrequested result, epoch", epoch_seconds_i, 0);
        end else begin
          want = due_q.pop_front();
          if (valid_res_i !== want.ok) begin
            report_mismatch("valid flag", longint'(valid_res_i), longint'(want.ok));
          end
          if (epoch_seconds_i !== want.secs) begin
            report_mismatch("epoch seconds", epoch_seconds_i, want.secs);
          end
          epochs_checked_o++;
          if (want.ok) epochs_valid_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_char(char_code_i);
        if (last_char_i) close_stamp();
      end
      epochs_due_o = due_q.size();
    end
  end

endmodule

// File: tb/sv/tb_iso8601_utc_to_epoch_parser_top.sv
`timescale 1ns / 1ps
// Testbench top: feeds timestamp strings to the parser, runs the checker beside it, gives verdict.
module tb_iso8601_utc_to_epoch_parser_top;
  import iso2ep_pkg::*;

  // the directed strings carry about 540 characters; this tops the run up to about 1100
  localparam int unsigned RANDOM_CHARS = 560;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // give some margin after the last result
  localparam int unsigned DRAIN_CYCLES = 16;
  // long enough for the two-entry queue and the output register to fill
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [7:0]  NUL          = 8'h00;

  // how the zone part of a generated stamp is written
  typedef enum logic [2:0] {
    ZF_END,
    ZF_UPPER_Z,
    ZF_LOWER_Z,
    ZF_PLUS,
    ZF_MINUS
  } zone_form_e;

  // ways a well-formed stamp gets broken
  typedef enum logic [1:0] {
    MU_SWAP,
    MU_CUT,
    MU_NUL,
    MU_TAIL
  } damage_e;

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [7:0]                char_code_i = 8'h00;
  logic                      last_char_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      valid_res_o;
  logic signed [EPOCH_W-1:0] epoch_seconds_o;

  int unsigned mismatches, epochs_due, epochs_checked, epochs_valid;
  int unsigned cycle_count = 0;
  int unsigned chars_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned send_idle_pct = 22;
  int unsigned recv_stall_pct = 57;
  bit          hold_req = 1'b0;
  logic [7:0]  text_q[$];

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  iso8601_utc_to_epoch_parser_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .last_char_i     (last_char_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .valid_res_o     (valid_res_o),
    .epoch_seconds_o (epoch_seconds_o)
  );

  iso2ep_epoch_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .char_code_i      (char_code_i),
    .last_char_i      (last_char_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .valid_res_i      (valid_res_o),
    .epoch_seconds_i  (epoch_seconds_o),
    .mismatches_o     (mismatches),
    .epochs_due_o     (epochs_due),
    .epochs_checked_o (epochs_checked),
    .epochs_valid_o   (epochs_valid)
  );

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("iso8601_utc_to_epoch_parser_top regression: fail");
      $finish;
    end
  end

  // Result side. Normally stalls at random; on request it holds off for a long
  // stretch so that the queue fills and the parser has to stall its input.
  always begin
    @(negedge clk_i);
    if (hold_req) begin
      out_stall_i <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_req = 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // One character transfer. Gaps only fall before an item, and valid stays high
  // from one item to the next, so it is never dropped and raised in one step.
  // While idle the character lines carry junk, which the parser must ignore.
  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i  <= 1'b0;
      char_code_i <= 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_char_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == int'(text_q.size()) - 1);
    text_q.delete();
    strings_sent++;
  endtask

  task automatic put_num(input int v, input int digits);
    int p;
    p = 1;
    repeat (digits - 1) p = p * 10;
    repeat (digits) begin
      text_q.push_back(8'("0" + (v / p) % 10));
      p = p / 10;
    end
  endtask

  task automatic cut_text(input int n);
    while (int'(text_q.size()) > n) void'(text_q.pop_back());
  endtask

  // frac_n = 0: no fraction; otherwise a dot and frac_n - 1 digits
  task automatic build_stamp(input int yr, input int mo, input int dy, input int hr,
                             input int mn, input int sc, input logic [7:0] sep,
                             input int frac_n, input zone_form_e zf, input int zh,
                             input int zm, input bit colon);
    put_num(yr, 4);
    text_q.push_back("-");
    put_num(mo, 2);
    text_q.push_back("-");
    put_num(dy, 2);
    text_q.push_back(sep);
    put_num(hr, 2);
    text_q.push_back(":");
    put_num(mn, 2);
    text_q.push_back(":");
    put_num(sc, 2);
    if (frac_n > 0) begin
      text_q.push_back(".");
      repeat (frac_n - 1) text_q.push_back(8'("0" + $urandom_range(9)));
    end
    case (zf)
      ZF_UPPER_Z: text_q.push_back("Z");
      ZF_LOWER_Z: text_q.push_back("z");
      ZF_PLUS, ZF_MINUS: begin
        text_q.push_back((zf == ZF_PLUS) ? "+" : "-");
        put_num(zh, 2);
        if (colon) text_q.push_back(":");
        put_num(zm, 2);
      end
      default: ;
    endcase
  endtask

  // Mostly in-range fields, with a fair share of out-of-range ones and of
  // days near the month end, where the leap-year rule matters.
  task automatic random_stamp();
    int yr, mo, dy, hr, mn, sc, zh, zm;
    yr = ($urandom_range(9) == 0) ? $urandom_range(9999) : $urandom_range(2100, 1970);
    mo = ($urandom_range(11) == 0) ? $urandom_range(99) : $urandom_range(12, 1);
    if ($urandom_range(11) == 0) dy = $urandom_range(99);
    else if ($urandom_range(3) == 0) dy = $urandom_range(31, 28);
    else dy = $urandom_range(31, 1);
    hr = ($urandom_range(11) == 0) ? $urandom_range(99) : $urandom_range(23);
    mn = ($urandom_range(11) == 0) ? $urandom_range(99) : $urandom_range(59);
    if ($urandom_range(11) == 0) sc = $urandom_range(99);
    else if ($urandom_range(9) == 0) sc = 60;
    else sc = $urandom_range(59);
    zh = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(23);
    zm = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
    build_stamp(yr, mo, dy, hr, mn, sc, $urandom_range(1) ? "T" : " ",
                $urandom_range(1) ? 0 : $urandom_range(8, 1),
                zone_form_e'($urandom_range(4)), zh, zm, $urandom_range(1));
  endtask

  task automatic damage_text();
    int k;
    k = $urandom_range(text_q.size() - 1);
    case (damage_e'($urandom_range(3)))
      MU_SWAP: text_q[k] = 8'($urandom);
      MU_CUT:  cut_text(k + 1);
      MU_NUL:  text_q[k] = NUL;       // rest of the string becomes junk
      default: text_q.push_back(8'($urandom));
    endcase
  endtask

  initial begin
    int unsigned base, rnd_sent, stage;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed strings ----
    // epoch origin, and both ends of the output range
    build_stamp(1970, 1, 1, 0, 0, 0, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    send_text();
    build_stamp(1970, 1, 1, 0, 0, 0, "T", 0, ZF_PLUS, 23, 59, 1);
    send_text();
    build_stamp(2100, 12, 31, 23, 59, 60, "T", 0, ZF_MINUS, 23, 59, 1);
    send_text();
    // leap days: 2000 is one, 2100 is not; space separator, lower-case zone, fraction
    build_stamp(2000, 2, 29, 12, 34, 56, " ", 7, ZF_LOWER_Z, 0, 0, 0);
    send_text();
    build_stamp(2100, 2, 29, 0, 0, 0, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    send_text();
    build_stamp(2024, 2, 29, 23, 59, 59, "T", 0, ZF_PLUS, 5, 30, 0);
    send_text();
    // years just outside the range, and all-zero / all-nine digits
    build_stamp(1969, 12, 31, 23, 59, 59, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    send_text();
    build_stamp(2101, 1, 1, 0, 0, 0, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    send_text();
    build_stamp(0, 0, 0, 0, 0, 0, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    send_text();
    build_stamp(9999, 99, 99, 99, 99, 99, "T", 0, ZF_MINUS, 99, 99, 1);
    send_text();
    // month, day and time fields one past their limits
    build_stamp(2023, 13, 1, 0, 0, 0, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    send_text();
    build_stamp(2023, 4, 31, 0, 0, 0, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    send_text();
    build_stamp(2023, 6, 15, 24, 0, 0, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    send_text();
    build_stamp(2023, 6, 15, 23, 60, 61, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    send_text();
    // end of string as the zone, bare dot then an offset
    build_stamp(2023, 6, 15, 8, 0, 0, "T", 0, ZF_END, 0, 0, 0);
    send_text();
    build_stamp(2023, 6, 15, 8, 0, 0, "T", 1, ZF_PLUS, 1, 0, 1);
    send_text();
    // bad offsets: hour 24, minute tens of 6, cut off after one digit
    build_stamp(2023, 6, 15, 8, 0, 0, "T", 0, ZF_PLUS, 24, 0, 1);
    send_text();
    build_stamp(2023, 6, 15, 8, 0, 0, "T", 0, ZF_MINUS, 12, 60, 0);
    send_text();
    build_stamp(2023, 6, 15, 8, 0, 0, "T", 0, ZF_PLUS, 12, 30, 1);
    cut_text(21);
    send_text();
    // characters after Z and after a complete offset
    build_stamp(2023, 6, 15, 8, 0, 0, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    text_q.push_back("Z");
    send_text();
    build_stamp(2023, 6, 15, 8, 0, 0, "T", 3, ZF_MINUS, 1, 0, 1);
    text_q.push_back("0");
    send_text();
    // short strings: date only, and a lone zero byte
    build_stamp(2023, 6, 15, 8, 0, 0, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    cut_text(10);
    send_text();
    text_q.push_back(NUL);
    send_text();
    // zero byte inside the date, and right after the seconds (a valid end)
    build_stamp(2023, 6, 15, 8, 0, 0, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    text_q[6] = NUL;
    send_text();
    build_stamp(2023, 6, 15, 8, 0, 0, "T", 0, ZF_END, 0, 0, 0);
    text_q.push_back(NUL);
    text_q.push_back("X");
    send_text();
    // wrong separators
    build_stamp(2023, 6, 15, 8, 0, 0, "T", 0, ZF_UPPER_Z, 0, 0, 0);
    text_q[10] = "X";
    text_q[4] = "/";
    send_text();

    // ---- random strings ----
    // Three stretches: sender idles 22% and receiver 57%, then swapped, then
    // no idling at all, opened by the long receiver hold-off.
    base = chars_sent;
    stage = 0;
    rnd_sent = 0;
    while (rnd_sent < RANDOM_CHARS) begin
      if (stage == 0 && rnd_sent >= RANDOM_CHARS / 3) begin
        stage = 1;
        send_idle_pct = 57;
        recv_stall_pct = 22;
      end else if (stage == 1 && rnd_sent >= 2 * RANDOM_CHARS / 3) begin
        stage = 2;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
      end
      case ($urandom_range(19))
        0, 1, 2: begin
          // noise: any bytes at all, zero bytes included
          repeat ($urandom_range(30, 1)) text_q.push_back(8'($urandom));
        end
        3, 4, 5, 6: begin
          random_stamp();
          damage_text();
        end
        default: random_stamp();
      endcase
      send_text();
      rnd_sent = chars_sent - base;
    end
    in_valid_i <= 1'b0;

    // let every pending result arrive, then watch a little longer for strays
    while (epochs_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d characters in %0d strings (directed edges, well-formed, broken, noise).",
             chars_sent, strings_sent);
    $display("Checked %0d epoch results, %0d of them valid; %0d mismatches.",
             epochs_checked, epochs_valid, mismatches);
    if (mismatches == 0) begin
      $display("iso8601_utc_to_epoch_parser_top regression: pass");
    end else begin
      $display("iso8601_utc_to_epoch_parser_top regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
sv/iso2ep_pkg.sv
sv/iso2ep_front.sv
sv/iso2ep_queue.sv
sv/iso2ep_back.sv
sv/iso8601_utc_to_epoch_parser_top.sv
tb/sv/iso2ep_epoch_checker.sv
tb/sv/tb_iso8601_utc_to_epoch_parser_top.sv
